// File: rtl/hrhp_pkg.sv
`default_nettype none

package hrhp_pkg;

  localparam int unsigned DefaultHistoryDepth = 10;

  // Weights are in tenths; the oldest entry weighs WgtBase.
  localparam int unsigned WgtBase = 10;

  localparam int unsigned RateW    = 8;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned AvgW     = 12;
  localparam int unsigned HeldW    = 4;
  localparam int unsigned HeldMax  = 15;
  localparam int unsigned FracBits = 4;

  localparam logic [LimitW-1:0] OutlierLimitRst = 8'd30;

  localparam logic KindAdd   = 1'b0;
  localparam logic KindClear = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_MULT,
    S_TEST,
    S_DIV,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// File: rtl/heart_rate_history_predictor.sv
`default_nettype none

// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_stall_o     kind_i, rate_bpm_i
// out      output     out_valid_o / out_stall_i   accepted_o, average_x16_o,
//                                                 entries_held_o, ready_res_o
// cfg      input      cfg_we_i                    cfg_wdata_i (outlier limit)
//
// One item at a time. A clear goes straight to the output state. An add reading walks
// the n held entries through the registered-read history RAM, multiplies and tests,
// on acceptance walks the new history again, then runs a restoring divider of one
// quotient bit per cycle over the DvdW-bit dividend, and loads the result; a
// rejection skips the second walk.
// Reset clears count, position and handshake state; the RAM is not cleared.
// A result waiting on out_stall_i does not block the next beat on the input.

module heart_rate_history_predictor #(
  parameter int unsigned HISTORY_DEPTH = hrhp_pkg::DefaultHistoryDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic [hrhp_pkg::RateW-1:0]    rate_bpm_i,

  input  wire logic                          cfg_we_i,
  input  wire logic [hrhp_pkg::LimitW-1:0]   cfg_wdata_i,

  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               accepted_o,
  output logic [hrhp_pkg::AvgW-1:0]          average_x16_o,
  output logic [hrhp_pkg::HeldW-1:0]         entries_held_o,
  output logic                               ready_res_o
);

  import hrhp_pkg::*;

  localparam int unsigned PtrW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CntW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned WgtMax  = WgtBase + HISTORY_DEPTH - 1;
  localparam int unsigned WgtW    = $clog2(WgtMax + 1);
  localparam int unsigned WsumMax = HISTORY_DEPTH * (2 * WgtBase + HISTORY_DEPTH - 1) / 2;
  localparam int unsigned WsumW   = $clog2(WsumMax + 1);
  localparam int unsigned SumMax  = 255 * WsumMax;
  localparam int unsigned SumW    = $clog2(SumMax + 1);
  localparam int unsigned ProdW   = RateW + WsumW;
  localparam int unsigned DvdW    = SumW + FracBits;
  localparam int unsigned DcntW   = $clog2(DvdW + 1);

  localparam logic [PtrW-1:0] LastPtr  = PtrW'(HISTORY_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(HISTORY_DEPTH);
  localparam logic [WgtW-1:0] WgtStart = WgtW'(WgtBase - 1);

  state_e state_q, state_d;

  logic [LimitW-1:0] limit_q;
  logic [PtrW-1:0]   wp_q, wp_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              final_q, final_d;
  logic [CntW-1:0]   iss_q, iss_d;
  logic [PtrW-1:0]   rp_q, rp_d;
  logic [WgtW-1:0]   wgt_q, wgt_d;
  logic              pv_q, pv_d;
  logic [WgtW-1:0]   pw_q, pw_d;
  logic [SumW-1:0]   s_q, s_d;
  logic [WsumW-1:0]  w_q, w_d;
  logic [RateW-1:0]  rate_q, rate_d;
  logic              acc_q, acc_d;
  logic [ProdW-1:0]  rw_q, rw_d;
  logic [ProdW-1:0]  lim_q, lim_d;
  logic [DvdW-1:0]   dq_q, dq_d;
  logic [WsumW-1:0]  rem_q, rem_d;
  logic [DcntW-1:0]  dcnt_q, dcnt_d;

  logic              out_valid_q, out_valid_d;
  logic              out_acc_q;
  logic [AvgW-1:0]   out_avg_q;
  logic [HeldW-1:0]  out_held_q;
  logic              out_ready_q;
  logic              out_load;

  logic [RateW-1:0]  hist_mem_q [HISTORY_DEPTH];
  logic [RateW-1:0]  rd_data_q;
  logic              rd_en;
  logic              mem_we;

  logic [PtrW-1:0]   wp_next;
  logic [CntW-1:0]   cnt_next;
  logic [ProdW-1:0]  s_ext;
  logic [ProdW-1:0]  diff_abs;
  logic [WsumW:0]    rem_shift;
  logic              q_bit;
  logic [HeldW-1:0]  held;

  assign wp_next  = (wp_q == LastPtr) ? '0 : wp_q + 1'b1;
  assign cnt_next = (cnt_q == FullCnt) ? cnt_q : cnt_q + 1'b1;
  assign s_ext    = ProdW'(s_q);
  assign diff_abs = (rw_q >= s_ext) ? (rw_q - s_ext) : (s_ext - rw_q);
  assign rem_shift = {rem_q, dq_q[DvdW-1]};
  assign q_bit     = (rem_shift >= {1'b0, w_q});
  assign held      = (32'(cnt_q) > HeldMax) ? HeldW'(HeldMax) : HeldW'(cnt_q);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    cnt_d    = cnt_q;
    final_d  = final_q;
    iss_d    = iss_q;
    rp_d     = rp_q;
    wgt_d    = wgt_q;
    pv_d     = 1'b0;
    pw_d     = pw_q;
    s_d      = s_q;
    w_d      = w_q;
    rate_d   = rate_q;
    acc_d    = acc_q;
    rw_d     = rw_q;
    lim_d    = lim_q;
    dq_d     = dq_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == KindClear) begin
            cnt_d   = '0;
            wp_d    = '0;
            acc_d   = 1'b0;
            dq_d    = '0;
            state_d = S_OUT;
          end else begin
            rate_d  = rate_bpm_i;
            iss_d   = '0;
            rp_d    = (wp_q == '0) ? LastPtr : wp_q - 1'b1;
            wgt_d   = WgtStart + WgtW'(cnt_q);
            s_d     = '0;
            w_d     = '0;
            final_d = 1'b0;
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        // Issue one read per cycle, newest first; accumulate the beat in flight.
        if (iss_q < cnt_q) begin
          rd_en = 1'b1;
          iss_d = iss_q + 1'b1;
          rp_d  = (rp_q == '0) ? LastPtr : rp_q - 1'b1;
          wgt_d = wgt_q - 1'b1;
          pv_d  = 1'b1;
          pw_d  = wgt_q;
        end
        if (pv_q) begin
          s_d = s_q + SumW'(rd_data_q) * SumW'(pw_q);
          w_d = w_q + WsumW'(pw_q);
        end
        if (!(iss_q < cnt_q) && !pv_q) begin
          if (final_q) begin
            dq_d    = {s_q, FracBits'(0)};
            rem_d   = '0;
            dcnt_d  = '0;
            state_d = S_DIV;
          end else begin
            state_d = S_MULT;
          end
        end
      end

      S_MULT: begin
        rw_d    = ProdW'(rate_q) * ProdW'(w_q);
        lim_d   = ProdW'(limit_q) * ProdW'(w_q);
        state_d = S_TEST;
      end

      S_TEST: begin
        if (diff_abs > lim_q) begin
          // Drop the reading; divide the sums already on hand.
          acc_d   = 1'b0;
          dq_d    = {s_q, FracBits'(0)};
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = S_DIV;
        end else begin
          mem_we  = 1'b1;
          acc_d   = 1'b1;
          wp_d    = wp_next;
          cnt_d   = cnt_next;
          iss_d   = '0;
          rp_d    = wp_q;
          wgt_d   = WgtStart + WgtW'(cnt_next);
          s_d     = '0;
          w_d     = '0;
          final_d = 1'b1;
          state_d = S_WALK;
        end
      end

      S_DIV: begin
        rem_d  = q_bit ? WsumW'(rem_shift - {1'b0, w_q}) : WsumW'(rem_shift);
        dq_d   = {dq_q[DvdW-2:0], q_bit};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DcntW'(DvdW - 1)) begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= OutlierLimitRst;
      wp_q        <= '0;
      cnt_q       <= '0;
      final_q     <= 1'b0;
      iss_q       <= '0;
      pv_q        <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      final_q     <= final_d;
      iss_q       <= iss_d;
      pv_q        <= pv_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q   <= rp_d;
    wgt_q  <= wgt_d;
    pw_q   <= pw_d;
    s_q    <= s_d;
    w_q    <= w_d;
    rate_q <= rate_d;
    acc_q  <= acc_d;
    rw_q   <= rw_d;
    lim_q  <= lim_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    if (out_load) begin
      out_acc_q   <= acc_q;
      out_avg_q   <= dq_q[AvgW-1:0];
      out_held_q  <= held;
      out_ready_q <= (cnt_q >= CntW'(2));
    end
  end

  // History RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem_q[wp_q] <= rate_q;
    end
    if (rd_en) begin
      rd_data_q <= hist_mem_q[rp_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_acc_q;
  assign average_x16_o  = out_avg_q;
  assign entries_held_o = out_held_q;
  assign ready_res_o    = out_ready_q;

endmodule

`default_nettype wire
